### hw/rtl/hci_uart_h4_deframer_assert.svh
//------------------------------------------------------------------------------
// HCI UART H4 deframer assertion macros
// Concurrent assertion wrappers shared by the deframer RTL. The checks vanish
// when the SYNTHESIS macro is defined.
//------------------------------------------------------------------------------
`ifndef HCI_UART_H4_DEFRAMER_ASSERT_SVH
`define HCI_UART_H4_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define H4_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define H4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define H4_ASSERT_NOW(lbl, ante, cons)
`define H4_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/hci_h4_pkg.sv
//------------------------------------------------------------------------------
// HCI H4 deframer package
// Packet kinds, status codes, register map and header sizes of the H4
// transport, shared by the tagged byte interface and the deframer.
//------------------------------------------------------------------------------
package hci_h4_pkg;

    typedef logic [2:0] kind_t;
    typedef logic [1:0] status_t;
    typedef logic [0:0] reg_idx_t;

    // Packet type byte values; zero marks an unknown type on the output.
    localparam kind_t KIND_NONE = 3'd0;
    localparam kind_t KIND_CMD  = 3'd1;
    localparam kind_t KIND_ACL  = 3'd2;
    localparam kind_t KIND_SCO  = 3'd3;
    localparam kind_t KIND_EVT  = 3'd4;
    localparam kind_t KIND_ISO  = 3'd5;

    localparam status_t STATUS_GOOD     = 2'd0;
    localparam status_t STATUS_UNKNOWN  = 2'd1;
    localparam status_t STATUS_OVERSIZE = 2'd2;

    localparam logic [7:0] LE_META_EVENT = 8'h3E;
    localparam logic [7:0] LE_ADV_REPORT = 8'h02;

    localparam int         MAX_LEN_W     = 17;
    localparam logic [16:0] MAX_LEN_RESET = 17'd1026;

    // APB register map: one 32-bit register every four bytes.
    localparam int       APB_ADDR_W  = 3;
    localparam reg_idx_t REG_MAX_LEN = 1'b0;
    localparam reg_idx_t REG_ISO_EN  = 1'b1;

    // Number of header bytes that follow the type byte.
    function automatic logic [2:0] header_size(input kind_t kind);
        logic [2:0] hlen;
        unique case (kind)
            KIND_CMD: hlen = 3'd3;
            KIND_ACL: hlen = 3'd4;
            KIND_SCO: hlen = 3'd3;
            KIND_EVT: hlen = 3'd2;
            KIND_ISO: hlen = 3'd4;
            default:  hlen = 3'd1;
        endcase
        return hlen;
    endfunction

endpackage

### hw/rtl/hci_h4_rx_if.sv
//------------------------------------------------------------------------------
// HCI H4 receive byte channel
// Valid/ready channel that carries one received UART byte per beat.
//------------------------------------------------------------------------------
interface hci_h4_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

### hw/rtl/hci_h4_tag_if.sv
//------------------------------------------------------------------------------
// HCI H4 tagged byte channel
// Valid/ready channel that carries one byte per beat together with its packet
// kind, framing marks, status and delivery decision.
//------------------------------------------------------------------------------
interface hci_h4_tag_if import hci_h4_pkg::*; ();

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    kind_t      packet_kind;
    logic       first_mark;
    logic       last_mark;
    status_t    status;
    logic       deliver;
    logic       discardable;

    modport source (
        output valid, output out_byte, output packet_kind, output first_mark,
        output last_mark, output status, output deliver, output discardable,
        input ready
    );
    modport sink (
        input valid, input out_byte, input packet_kind, input first_mark,
        input last_mark, input status, input deliver, input discardable,
        output ready
    );

endinterface

### hw/rtl/hci_uart_h4_deframer.sv
//------------------------------------------------------------------------------
// HCI UART H4 deframer
// Splits the received H4 byte stream into packets: tags each byte with its
// packet kind, first and last marks and status, and decides delivery on the
// last byte of every packet.
//
//   channel   kind        width    beat
//   h4_rx     sink        8        one received byte
//   h4_tag    source      17       byte, kind, marks, status, deliver, discard
//   apb       slave       32       max_packet_len at 0x0, iso_enable at 0x4
//
// Each byte passes through the input register and then the result register
// before its tag appears on h4_tag. One byte per cycle is sustained while
// h4_tag is ready; the framing state updates in one pass. A stall on h4_tag
// backs up into the input register, and h4_rx.ready drops only when both
// registers hold bytes. Reset restores the register defaults.
//------------------------------------------------------------------------------
`include "hci_uart_h4_deframer_assert.svh"

module hci_uart_h4_deframer import hci_h4_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    hci_h4_rx_if.sink             h4_rx,
    hci_h4_tag_if.source          h4_tag,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    // Configuration
    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 iso_en_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_acc;
    logic       advance;

    // Framing state
    phase_t      phase_reg,    phase_next;
    kind_t       kind_reg,     kind_next;
    logic [2:0]  hpos_reg,     hpos_next;
    logic [7:0]  len_lo_reg,   len_lo_next;
    logic [15:0] remain_reg,   remain_next;
    logic [7:0]  evt_code_reg, evt_code_next;
    logic        advert_reg,   advert_next;
    logic        over_reg,     over_next;

    // Result of the byte in the input register
    kind_t   res_kind;
    logic    res_first;
    logic    res_last;
    status_t res_status;
    logic    res_deliver;
    logic    res_discard;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    kind_t      out_kind_reg;
    logic       out_first_reg;
    logic       out_last_reg;
    status_t    out_status_reg;
    logic       out_deliver_reg;
    logic       out_discard_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_LEN: prdata = {{(32-MAX_LEN_W){1'b0}}, max_len_reg};
            REG_ISO_EN:  prdata = {31'b0, iso_en_reg};
            default:     prdata = 32'b0;
        endcase
    end

    assign advance      = in_valid_reg && (!out_valid_reg || h4_tag.ready);
    assign h4_rx.ready  = !in_valid_reg || advance;
    assign in_acc       = h4_rx.valid && h4_rx.ready;

    // Framing logic for the byte in the input register.
    always_comb
    begin
        logic        have_len;
        logic [15:0] payload;
        logic [16:0] total;
        logic [15:0] remain_dec;
        logic        unknown;

        have_len      = 1'b0;
        payload       = 16'd0;
        total         = 17'd0;
        remain_dec    = 16'd0;
        unknown       = 1'b0;

        phase_next    = phase_reg;
        kind_next     = kind_reg;
        hpos_next     = hpos_reg;
        len_lo_next   = len_lo_reg;
        remain_next   = remain_reg;
        evt_code_next = evt_code_reg;
        advert_next   = advert_reg;
        over_next     = over_reg;

        res_kind      = kind_reg;
        res_first     = 1'b0;
        res_last      = 1'b0;
        res_status    = STATUS_GOOD;
        res_deliver   = 1'b0;
        res_discard   = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                unique case (kind_reg)
                    KIND_CMD, KIND_SCO:
                    begin
                        if (hpos_reg == 3'd2)
                        begin
                            payload  = {8'd0, in_byte_reg};
                            have_len = 1'b1;
                        end
                    end
                    KIND_EVT:
                    begin
                        if (hpos_reg == 3'd0)
                        begin
                            evt_code_next = in_byte_reg;
                        end
                        else if (hpos_reg == 3'd1)
                        begin
                            payload  = {8'd0, in_byte_reg};
                            have_len = 1'b1;
                        end
                    end
                    KIND_ACL, KIND_ISO:
                    begin
                        if (hpos_reg == 3'd2)
                        begin
                            len_lo_next = in_byte_reg;
                        end
                        else if (hpos_reg == 3'd3)
                        begin
                            if (kind_reg == KIND_ISO)
                            begin
                                payload = {2'b00, in_byte_reg[5:0], len_lo_reg};
                            end
                            else
                            begin
                                payload = {in_byte_reg, len_lo_reg};
                            end
                            have_len = 1'b1;
                        end
                    end
                    default:
                    begin
                        // A kind that cannot be in this phase closes at once.
                        have_len = 1'b1;
                    end
                endcase
                hpos_next = hpos_reg + 3'd1;
                if (have_len)
                begin
                    total = 17'd1 + {14'd0, header_size(kind_reg)} + {1'b0, payload};
                    if (total > max_len_reg)
                    begin
                        over_next = 1'b1;
                    end
                    if (payload == 16'd0)
                    begin
                        res_last = 1'b1;
                    end
                    else
                    begin
                        phase_next  = PH_PAYLOAD;
                        remain_next = payload;
                        hpos_next   = 3'd0;
                    end
                end
                res_status = over_next ? STATUS_OVERSIZE : STATUS_GOOD;
            end
            PH_PAYLOAD:
            begin
                // Position zero here means the first payload byte.
                if (hpos_reg == 3'd0)
                begin
                    if (kind_reg == KIND_EVT && evt_code_reg == LE_META_EVENT &&
                        in_byte_reg == LE_ADV_REPORT)
                    begin
                        advert_next = 1'b1;
                    end
                    hpos_next = 3'd1;
                end
                res_status  = over_reg ? STATUS_OVERSIZE : STATUS_GOOD;
                remain_dec  = (remain_reg != 16'd0) ? remain_reg - 16'd1 : remain_reg;
                remain_next = remain_dec;
                res_last    = (remain_dec == 16'd0);
            end
            default:
            begin
                res_first = 1'b1;
                if (in_byte_reg >= {5'd0, KIND_CMD} && in_byte_reg <= {5'd0, KIND_ISO})
                begin
                    kind_next     = in_byte_reg[2:0];
                    res_kind      = in_byte_reg[2:0];
                    phase_next    = PH_HEADER;
                    hpos_next     = 3'd0;
                    len_lo_next   = 8'd0;
                    evt_code_next = 8'd0;
                    advert_next   = 1'b0;
                    over_next     = 1'b0;
                    remain_next   = 16'd0;
                end
                else
                begin
                    unknown    = 1'b1;
                    res_kind   = KIND_NONE;
                    res_last   = 1'b1;
                    res_status = STATUS_UNKNOWN;
                end
            end
        endcase

        if (res_last && !unknown)
        begin
            res_deliver = !over_next &&
                          (kind_reg == KIND_EVT || kind_reg == KIND_ACL ||
                           (kind_reg == KIND_ISO && iso_en_reg));
            res_discard = res_deliver && kind_reg == KIND_EVT && advert_next;
        end

        if (res_last)
        begin
            phase_next  = PH_TYPE;
            hpos_next   = 3'd0;
            remain_next = 16'd0;
            advert_next = 1'b0;
            over_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            iso_en_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_TYPE;
            kind_reg      <= KIND_NONE;
            hpos_reg      <= 3'd0;
            len_lo_reg    <= 8'd0;
            remain_reg    <= 16'd0;
            evt_code_reg  <= 8'd0;
            advert_reg    <= 1'b0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_MAX_LEN: max_len_reg <= pwdata[MAX_LEN_W-1:0];
                    REG_ISO_EN:  iso_en_reg  <= pwdata[0];
                    default:     ;
                endcase
            end

            if (in_acc)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                kind_reg      <= kind_next;
                hpos_reg      <= hpos_next;
                len_lo_reg    <= len_lo_next;
                remain_reg    <= remain_next;
                evt_code_reg  <= evt_code_next;
                advert_reg    <= advert_next;
                over_reg      <= over_next;
                out_valid_reg <= 1'b1;
            end
            else if (h4_tag.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_byte_reg <= h4_rx.rx_byte;
        end
        if (advance)
        begin
            out_byte_reg    <= in_byte_reg;
            out_kind_reg    <= res_kind;
            out_first_reg   <= res_first;
            out_last_reg    <= res_last;
            out_status_reg  <= res_status;
            out_deliver_reg <= res_deliver;
            out_discard_reg <= res_discard;
        end
    end

    assign h4_tag.valid       = out_valid_reg;
    assign h4_tag.out_byte    = out_byte_reg;
    assign h4_tag.packet_kind = out_kind_reg;
    assign h4_tag.first_mark  = out_first_reg;
    assign h4_tag.last_mark   = out_last_reg;
    assign h4_tag.status      = out_status_reg;
    assign h4_tag.deliver     = out_deliver_reg;
    assign h4_tag.discardable = out_discard_reg;

    // A delivered packet always ends good.
    `H4_ASSERT_NOW(a_deliver_good, out_valid_reg && out_deliver_reg,
        out_last_reg && out_status_reg == STATUS_GOOD)
    // Only a delivered event may be marked discardable.
    `H4_ASSERT_NOW(a_discard_evt, out_valid_reg && out_discard_reg,
        out_deliver_reg && out_kind_reg == KIND_EVT)
    // An unknown type byte is a packet of its own.
    `H4_ASSERT_NOW(a_unknown_single, out_valid_reg && out_kind_reg == KIND_NONE,
        out_first_reg && out_last_reg && out_status_reg == STATUS_UNKNOWN)
    // The payload phase always has bytes left to count.
    `H4_ASSERT_NOW(a_payload_count, phase_reg == PH_PAYLOAD, remain_reg != 16'd0)
    // The byte that closes a packet returns the deframer to the type byte.
    `H4_ASSERT_NEXT(a_last_to_type, advance && res_last, phase_reg == PH_TYPE)

endmodule

### sim/tb_hci_uart_h4_deframer.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// HCI UART H4 deframer testbench
// Feeds H4 byte streams through the receive channel and checks every tagged
// beat on the output against a cycle-free model of the framing rules. Runs
// directed packets, length-limit and ISO-disable cases, a back-pressure case
// and random packet streams under several register settings, with random
// idle bursts on both channels.
//------------------------------------------------------------------------------
module tb_hci_uart_h4_deframer;

    import hci_h4_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_BYTES   = 180;
    localparam int RANDOM_PHASES = 6;

    typedef enum logic [1:0] {PH_TYPE, PH_HEADER, PH_PAYLOAD} rx_phase_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       first;
        logic       last;
        status_t    status;
        logic       deliver;
        logic       discard;
    } tag_beat_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    hci_h4_rx_if  rx_if ();
    hci_h4_tag_if tag_if ();

    hci_uart_h4_deframer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .h4_rx   (rx_if),
        .h4_tag  (tag_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register shadows and framing state of the model.
    logic [16:0] cfg_max_len = MAX_LEN_RESET;
    logic        cfg_iso_en  = 1'b1;
    rx_phase_t   rx_phase    = PH_TYPE;
    kind_t       cur_kind    = KIND_NONE;
    logic [2:0]  hdr_pos     = '0;
    logic [7:0]  len_lo      = '0;
    logic [16:0] bytes_left  = '0;
    logic [7:0]  evt_code    = '0;
    logic        adv_seen    = 1'b0;
    logic        too_long    = 1'b0;

    tag_beat_t expected_tags[$];
    int        fail_count    = 0;
    int        bytes_sent    = 0;
    int        sink_hold_req = 0;
    logic      src_idle_en   = 1'b1;
    logic      sink_idle_en  = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_packet();
        rx_phase   = PH_TYPE;
        hdr_pos    = '0;
        bytes_left = '0;
        adv_seen   = 1'b0;
        too_long   = 1'b0;
    endfunction

    // Advances the framing state by one received byte and returns its tag.
    function automatic tag_beat_t deframe_byte(input logic [7:0] b);
        tag_beat_t   r;
        logic [2:0]  pos;
        logic [2:0]  hlen;
        logic [15:0] plen;
        logic        have_len;
        r        = '0;
        r.data   = b;
        r.kind   = KIND_NONE;
        r.status = STATUS_GOOD;
        case (rx_phase)
            PH_HEADER:
            begin
                pos      = hdr_pos;
                have_len = 1'b0;
                plen     = '0;
                case (cur_kind)
                    KIND_CMD, KIND_SCO:
                    begin
                        hlen = 3'd3;
                        if (pos == 3'd2)
                        begin
                            plen     = {8'h00, b};
                            have_len = 1'b1;
                        end
                    end
                    KIND_EVT:
                    begin
                        hlen = 3'd2;
                        if (pos == 3'd0)
                            evt_code = b;
                        else if (pos == 3'd1)
                        begin
                            plen     = {8'h00, b};
                            have_len = 1'b1;
                        end
                    end
                    KIND_ACL, KIND_ISO:
                    begin
                        hlen = 3'd4;
                        if (pos == 3'd2)
                            len_lo = b;
                        else if (pos == 3'd3)
                        begin
                            plen = {b, len_lo};
                            if (cur_kind == KIND_ISO)
                                plen[15:14] = 2'b00;
                            have_len = 1'b1;
                        end
                    end
                    default:
                    begin
                        hlen     = 3'd1;
                        have_len = 1'b1;
                    end
                endcase
                hdr_pos = pos + 3'd1;
                r.kind  = cur_kind;
                if (have_len)
                begin
                    if (32'd1 + hlen + plen > cfg_max_len)
                        too_long = 1'b1;
                    if (plen == 16'd0)
                        r.last = 1'b1;
                    else
                    begin
                        rx_phase   = PH_PAYLOAD;
                        bytes_left = {1'b0, plen};
                        hdr_pos    = '0;
                    end
                end
                r.status = too_long ? STATUS_OVERSIZE : STATUS_GOOD;
            end
            PH_PAYLOAD:
            begin
                // The first payload byte of an LE meta event is its subevent code.
                if (hdr_pos == 3'd0)
                begin
                    if (cur_kind == KIND_EVT && evt_code == LE_META_EVENT &&
                        b == LE_ADV_REPORT)
                        adv_seen = 1'b1;
                    hdr_pos = 3'd1;
                end
                r.kind   = cur_kind;
                r.status = too_long ? STATUS_OVERSIZE : STATUS_GOOD;
                if (bytes_left != '0)
                    bytes_left = bytes_left - 17'd1;
                if (bytes_left == '0)
                    r.last = 1'b1;
            end
            default:
            begin
                r.first = 1'b1;
                if (b >= 8'(KIND_CMD) && b <= 8'(KIND_ISO))
                begin
                    cur_kind   = b[2:0];
                    r.kind     = cur_kind;
                    rx_phase   = PH_HEADER;
                    hdr_pos    = '0;
                    len_lo     = '0;
                    evt_code   = '0;
                    adv_seen   = 1'b0;
                    too_long   = 1'b0;
                    bytes_left = '0;
                end
                else
                begin
                    r.last   = 1'b1;
                    r.status = STATUS_UNKNOWN;
                    close_packet();
                end
            end
        endcase
        if (r.last && r.status != STATUS_UNKNOWN)
        begin
            r.deliver = !too_long && (cur_kind == KIND_EVT || cur_kind == KIND_ACL ||
                                      (cur_kind == KIND_ISO && cfg_iso_en));
            r.discard = r.deliver && cur_kind == KIND_EVT && adv_seen;
            close_packet();
        end
        return r;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Every tagged beat is matched against the oldest expected tag.
    always @(posedge clk)
    begin : check_tags
        tag_beat_t got;
        tag_beat_t want;
        if (rst_n && tag_if.valid && tag_if.ready)
        begin
            got.data    = tag_if.out_byte;
            got.kind    = tag_if.packet_kind;
            got.first   = tag_if.first_mark;
            got.last    = tag_if.last_mark;
            got.status  = tag_if.status;
            got.deliver = tag_if.deliver;
            got.discard = tag_if.discardable;
            if (expected_tags.size() == 0)
                log_failure($sformatf("unexpected beat at %0t: byte %02h kind %0d",
                                      $realtime, got.data, got.kind));
            else
            begin
                want = expected_tags.pop_front();
                if (got !== want)
                    log_failure($sformatf(
                        {"mismatch at %0t: expected byte %02h kind %0d first %0b last %0b",
                         " status %0d deliver %0b discard %0b; got byte %02h kind %0d",
                         " first %0b last %0b status %0d deliver %0b discard %0b"},
                        $realtime, want.data, want.kind, want.first, want.last,
                        want.status, want.deliver, want.discard, got.data, got.kind,
                        got.first, got.last, got.status, got.deliver, got.discard));
            end
        end
    end

    // Output side: random stall bursts, or one long hold-off on request.
    initial
    begin : tag_sink
        tag_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                tag_if.ready <= 1'b0;
                repeat (sink_hold_req) @(posedge clk);
                sink_hold_req = 0;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                tag_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            tag_if.ready <= 1'b1;
        end
    end

    // Ends the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (tag_if.valid && tag_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offers one byte and returns at the edge where it is taken. Valid stays
    // high so that the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        expected_tags.push_back(deframe_byte(b));
        bytes_sent++;
    endtask

    task automatic send_packet(input kind_t k, input int len, input logic [7:0] code,
                               input logic adv);
        logic [7:0] hi;
        send_byte(8'(k));
        case (k)
            KIND_CMD, KIND_SCO:
            begin
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                send_byte(len[7:0]);
            end
            KIND_EVT:
            begin
                send_byte(code);
                send_byte(len[7:0]);
            end
            default:
            begin
                hi = len[15:8];
                // The two top bits of the ISO length are not part of it.
                if (k == KIND_ISO)
                    hi[7:6] = 2'($urandom_range(0, 3));
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                send_byte(len[7:0]);
                send_byte(hi);
            end
        endcase
        for (int i = 0; i < len; i++)
            send_byte((i == 0 && adv) ? LE_ADV_REPORT : 8'($urandom));
    endtask

    task automatic send_random_packet();
        int         sel;
        int         len;
        int         cut;
        kind_t      k;
        logic [7:0] code;
        logic       adv;
        sel = $urandom_range(0, 19);
        if (sel < 2)
        begin
            // Unknown type byte.
            send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(6, 255)));
        end
        else if (sel < 4)
        begin
            // Header cut short; the following bytes complete it as they come.
            case ($urandom_range(0, 2))
                0:       k = KIND_CMD;
                1:       k = KIND_SCO;
                default: k = KIND_EVT;
            endcase
            send_byte(8'(k));
            cut = $urandom_range(0, (k == KIND_EVT) ? 1 : 2);
            repeat (cut) send_byte(8'($urandom));
        end
        else
        begin
            k    = kind_t'($urandom_range(1, 5));
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                               : $urandom_range(0, 24);
            if ((k == KIND_CMD || k == KIND_SCO || k == KIND_EVT) && len > 255)
                len = 255;
            code = $urandom_range(0, 1) ? LE_META_EVENT : 8'($urandom);
            adv  = (k == KIND_EVT) && ($urandom_range(0, 1) == 1);
            send_packet(k, len, code, adv);
        end
    endtask

    // Stops offering bytes and waits until every expected tag has come out.
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_LEN)
            cfg_max_len = value[16:0];
        else
            cfg_iso_en = value[0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [16:0] max_len, input logic iso_en);
        drain_results();
        apb_write(REG_MAX_LEN, {15'd0, max_len});
        apb_write(REG_ISO_EN, {31'd0, iso_en});
    endtask

    task automatic test_directed();
        logic [7:0] seq[] = '{
            8'h00, 8'hFF,
            8'h01, 8'hAA, 8'hBB, 8'h00,
            8'h02, 8'h01, 8'h00, 8'h01, 8'h00, 8'h7E,
            8'h03, 8'h01, 8'h02, 8'h01, 8'h55,
            8'h04, 8'h3E, 8'h02, 8'h02, 8'h11,
            8'h04, 8'h05, 8'h00,
            8'h05, 8'h10, 8'h20, 8'h01, 8'hC0, 8'h7F
        };
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_length_limits();
        set_config(17'd5, 1'b1);
        send_packet(KIND_EVT, 2, 8'h0E, 1'b0);
        send_packet(KIND_EVT, 3, LE_META_EVENT, 1'b1);
        send_packet(KIND_CMD, 1, 8'h00, 1'b0);
        send_packet(KIND_CMD, 2, 8'h00, 1'b0);
        send_packet(KIND_ACL, 0, 8'h00, 1'b0);
        send_packet(KIND_ACL, 1, 8'h00, 1'b0);
        send_packet(KIND_ISO, 0, 8'h00, 1'b0);
        // One ACL packet exactly at the limit and one a byte over it.
        set_config(17'd100, 1'b1);
        send_packet(KIND_ACL, 95, 8'h00, 1'b0);
        send_packet(KIND_ACL, 96, 8'h00, 1'b0);
        set_config(17'd65540, 1'b1);
        send_packet(KIND_ISO, 40, 8'h00, 1'b0);
    endtask

    task automatic test_iso_disable();
        set_config(MAX_LEN_RESET, 1'b0);
        send_packet(KIND_ISO, 0, 8'h00, 1'b0);
        send_packet(KIND_ISO, 3, 8'h00, 1'b0);
        send_packet(KIND_EVT, 1, 8'h0F, 1'b0);
        send_packet(KIND_ACL, 2, 8'h00, 1'b0);
        set_config(MAX_LEN_RESET, 1'b1);
        send_packet(KIND_ISO, 2, 8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        sink_hold_req = LONG_HOLD;
        repeat (8) send_random_packet();
        drain_results();
        repeat (4) send_random_packet();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_random();
        int          start;
        logic [16:0] max_len;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:       max_len = 17'd5;
                1:       max_len = MAX_LEN_RESET;
                2:       max_len = 17'd65540;
                3:       max_len = 17'($urandom_range(5, 300));
                default: max_len = 17'($urandom_range(5, 65540));
            endcase
            set_config(max_len, 1'($urandom_range(0, 1)));
            if (p == RANDOM_PHASES - 1)
            begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            else
            begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_packet();
        end
    endtask

    initial
    begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_length_limits();
        test_iso_disable();
        test_backpressure();
        test_random();

        rx_if.valid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_tags.size() != 0)
            log_failure($sformatf("%0d expected beats never arrived",
                                  expected_tags.size()));
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hci_h4_pkg.sv
hw/rtl/hci_h4_rx_if.sv
hw/rtl/hci_h4_tag_if.sv
hw/rtl/hci_uart_h4_deframer.sv
sim/tb_hci_uart_h4_deframer.sv
